// ===== design/dtmf_pkg.sv =====
// shared constants, types and key decode for the dual-tone generator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package dtmf_pkg;

  localparam int unsigned TableLengthDefault  = 200;
  localparam int unsigned SampleRateDefault   = 44100;
  localparam int unsigned SineEntriesDefault  = 1024;

  localparam int unsigned NumTones = 8;
  localparam int unsigned ToneIdxW = 3;

  // row tones first, then column tones
  localparam int unsigned ToneFreqHz [NumTones] = '{
    697, 770, 852, 941, 1209, 1336, 1477, 1633
  };

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef enum logic [1:0] {
    StIdle,
    StSweep,
    StDrain,
    StDone
  } dtmf_state_e;

  typedef struct packed {
    logic                step;
    logic                wrap;
    logic [ToneIdxW-1:0] tone;
  } acc_ctrl_t;

  typedef struct packed {
    logic       known;
    logic [1:0] row;
    logic [1:0] col;
  } key_dec_t;

  function automatic key_dec_t decode_key(logic [7:0] key);
    key_dec_t d;
    d = '{known: 1'b1, row: 2'd0, col: 2'd0};
    unique case (key)
      "1":      begin d.row = 2'd0; d.col = 2'd0; end
      "2":      begin d.row = 2'd0; d.col = 2'd1; end
      "3":      begin d.row = 2'd0; d.col = 2'd2; end
      "4":      begin d.row = 2'd1; d.col = 2'd0; end
      "5":      begin d.row = 2'd1; d.col = 2'd1; end
      "6":      begin d.row = 2'd1; d.col = 2'd2; end
      "7":      begin d.row = 2'd2; d.col = 2'd0; end
      "8":      begin d.row = 2'd2; d.col = 2'd1; end
      "9":      begin d.row = 2'd2; d.col = 2'd2; end
      "*":      begin d.row = 2'd3; d.col = 2'd0; end
      "0":      begin d.row = 2'd3; d.col = 2'd1; end
      "#":      begin d.row = 2'd3; d.col = 2'd2; end
      "A", "a": begin d.row = 2'd0; d.col = 2'd3; end
      "B", "b": begin d.row = 2'd1; d.col = 2'd3; end
      "C", "c": begin d.row = 2'd2; d.col = 2'd3; end
      "D", "d": begin d.row = 2'd3; d.col = 2'd3; end
      default:  d.known = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ===== design/dtmf_sine_rom.sv =====
// sine rom, Q1.14, filled at elaboration from a Q30 Taylor series folded by quadrant
// depends on dtmf_pkg; one registered read port
`timescale 1ns / 1ps

module dtmf_sine_rom #(
  parameter int unsigned SineEntries = dtmf_pkg::SineEntriesDefault,
  localparam int unsigned AddrW      = $clog2(SineEntries)
) (
  input  logic                    clk_i,
  input  logic                    rd_en_i,
  input  logic [AddrW-1:0]        rd_addr_i,
  output logic signed [15:0]      rd_data_o
);

  typedef logic signed [15:0] rom_t [SineEntries];

  function automatic logic signed [15:0] sine_entry(int unsigned k);
    logic [63:0] n;
    logic [63:0] q;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] mag;
    logic        neg;
    n   = 64'(SineEntries);
    q   = 64'(k) << 2;
    neg = 1'b0;
    if (q >= 2 * n) begin
      neg = 1'b1;
      q   = q - 2 * n;
    end
    if (q > n) q = 2 * n - q;
    x    = (dtmf_pkg::HalfPiQ30 * q + n / 2) / SineEntries;
    x2   = (x * x) >> 30;
    sum  = x;
    term = ((x * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + term;
    mag  = (sum + 64'd32768) >> 16;
    return neg ? -16'(mag) : 16'(mag);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int unsigned k = 0; k < SineEntries; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

  localparam rom_t SineTable = build_rom();

  logic signed [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= SineTable[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/dtmf_phase_acc.sv =====
// eight phase accumulators, one per tone, advanced one at a time by a shared adder
// depends on dtmf_pkg; holds floor(n*f*N/fs) mod N and its remainder for each tone
`timescale 1ns / 1ps

module dtmf_phase_acc #(
  parameter int unsigned SineEntries  = dtmf_pkg::SineEntriesDefault,
  parameter int unsigned SampleRateHz = dtmf_pkg::SampleRateDefault,
  localparam int unsigned QW          = $clog2(SineEntries),
  localparam int unsigned RW          = $clog2(SampleRateHz)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dtmf_pkg::acc_ctrl_t ctrl_i,
  output logic [QW-1:0]       phase_o
);

  typedef logic [QW-1:0] qinc_t [dtmf_pkg::NumTones];
  typedef logic [RW-1:0] rinc_t [dtmf_pkg::NumTones];

  function automatic qinc_t build_qinc();
    qinc_t t;
    for (int j = 0; j < dtmf_pkg::NumTones; j++) begin
      t[j] = QW'((longint'(dtmf_pkg::ToneFreqHz[j]) * SineEntries / SampleRateHz)
                 % SineEntries);
    end
    return t;
  endfunction

  function automatic rinc_t build_rinc();
    rinc_t t;
    for (int j = 0; j < dtmf_pkg::NumTones; j++) begin
      t[j] = RW'((longint'(dtmf_pkg::ToneFreqHz[j]) * SineEntries) % SampleRateHz);
    end
    return t;
  endfunction

  localparam qinc_t QInc = build_qinc();
  localparam rinc_t RInc = build_rinc();

  logic [QW-1:0] phase_q [dtmf_pkg::NumTones];
  logic [RW-1:0] rem_q   [dtmf_pkg::NumTones];

  logic [QW-1:0] cur_q;
  logic [RW-1:0] cur_r;
  logic [RW:0]   r_sum;
  logic          carry;
  logic [RW-1:0] r_next;
  logic [QW:0]   q_sum;
  logic [QW-1:0] q_next;

  always_comb begin
    cur_q  = phase_q[ctrl_i.tone];
    cur_r  = rem_q[ctrl_i.tone];
    r_sum  = {1'b0, cur_r} + {1'b0, RInc[ctrl_i.tone]};
    carry  = (r_sum >= (RW+1)'(SampleRateHz));
    r_next = carry ? RW'(r_sum - (RW+1)'(SampleRateHz)) : RW'(r_sum);
    q_sum  = {1'b0, cur_q} + {1'b0, QInc[ctrl_i.tone]} + {{QW{1'b0}}, carry};
    q_next = (q_sum >= (QW+1)'(SineEntries)) ? QW'(q_sum - (QW+1)'(SineEntries))
                                             : QW'(q_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < dtmf_pkg::NumTones; j++) begin
        phase_q[j] <= '0;
        rem_q[j]   <= '0;
      end
    end else if (ctrl_i.step) begin
      // sample index wraps to zero, so every tone restarts at phase zero
      phase_q[ctrl_i.tone] <= ctrl_i.wrap ? '0 : q_next;
      rem_q[ctrl_i.tone]   <= ctrl_i.wrap ? '0 : r_next;
    end
  end

  assign phase_o = cur_q;

endmodule

// ===== design/dtmf_dual_tone_generator.sv =====
// dual-tone generator top: key decode, sequencer, sum and saturation, output register
// depends on dtmf_pkg, dtmf_phase_acc and dtmf_sine_rom
// an input beat passes the sweep, drain and done states before its output beat is offered
// a new key is taken only back in idle, after the accept, the 8-step walk of the shared phase
// adder, the rom drain and the output load, which waits while the output register is full
// reset clears the tone pair, sample index and phase accumulators; the rom is constant
`timescale 1ns / 1ps

module dtmf_dual_tone_generator #(
  parameter int unsigned TableLength  = dtmf_pkg::TableLengthDefault,
  parameter int unsigned SampleRateHz = dtmf_pkg::SampleRateDefault,
  parameter int unsigned SineEntries  = dtmf_pkg::SineEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] key
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] sample
  output logic        m_axis_tuser_o    // [0] key_known
);

  localparam int unsigned IdxW  = (TableLength > 1) ? $clog2(TableLength) : 1;
  localparam int unsigned AddrW = $clog2(SineEntries);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableLength - 1);
  localparam logic [dtmf_pkg::ToneIdxW-1:0] LastTone =
    dtmf_pkg::ToneIdxW'(dtmf_pkg::NumTones - 1);

  dtmf_pkg::dtmf_state_e state_q, state_d;

  logic [dtmf_pkg::ToneIdxW-1:0] tone_q, tone_d;
  logic [1:0]         row_q, row_d;
  logic [1:0]         col_q, col_d;
  logic               known_q, known_d;
  logic [IdxW-1:0]    index_q, index_d;
  logic               pend_q, pend_d;
  logic signed [16:0] sum_q, sum_d;
  logic               out_valid_q, out_valid_d;
  logic [15:0]        out_sample_q, out_sample_d;
  logic               out_known_q, out_known_d;

  logic                accept;
  logic                rom_rd;
  logic [AddrW-1:0]    phase;
  logic signed [15:0]  rom_data;
  logic [15:0]         sat_sample;
  dtmf_pkg::acc_ctrl_t acc_ctrl;
  dtmf_pkg::key_dec_t  key_dec;

  dtmf_phase_acc #(
    .SineEntries (SineEntries),
    .SampleRateHz(SampleRateHz)
  ) u_phase_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .phase_o(phase)
  );

  dtmf_sine_rom #(
    .SineEntries(SineEntries)
  ) u_sine_rom (
    .clk_i    (clk_i),
    .rd_en_i  (rom_rd),
    .rd_addr_i(phase),
    .rd_data_o(rom_data)
  );

  assign s_axis_tready_o = (state_q == dtmf_pkg::StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign key_dec         = dtmf_pkg::decode_key(s_axis_tdata_i);

  always_comb begin
    if (sum_q > 17'sd32767) begin
      sat_sample = 16'h7fff;
    end else if (sum_q < -17'sd32768) begin
      sat_sample = 16'h8000;
    end else begin
      sat_sample = sum_q[15:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    tone_d       = tone_q;
    row_d        = row_q;
    col_d        = col_q;
    known_d      = known_q;
    index_d      = index_q;
    pend_d       = 1'b0;
    sum_d        = sum_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_sample_d = out_sample_q;
    out_known_d  = out_known_q;
    rom_rd       = 1'b0;
    acc_ctrl     = '{step: 1'b0, wrap: (index_q == LastIdx), tone: tone_q};

    // rom data arrives in the cycle after its read
    if (pend_q) sum_d = sum_q + {rom_data[15], rom_data};

    unique case (state_q)
      dtmf_pkg::StIdle: begin
        if (accept) begin
          if (key_dec.known) begin
            row_d = key_dec.row;
            col_d = key_dec.col;
          end
          known_d = key_dec.known;
          sum_d   = '0;
          tone_d  = '0;
          state_d = dtmf_pkg::StSweep;
        end
      end
      dtmf_pkg::StSweep: begin
        acc_ctrl.step = 1'b1;
        rom_rd = (tone_q == {1'b0, row_q}) || (tone_q == {1'b1, col_q});
        pend_d = rom_rd;
        tone_d = tone_q + 1'b1;
        if (tone_q == LastTone) state_d = dtmf_pkg::StDrain;
      end
      dtmf_pkg::StDrain: begin
        state_d = dtmf_pkg::StDone;
      end
      dtmf_pkg::StDone: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_sample_d = sat_sample;
          out_known_d  = known_q;
          index_d      = (index_q == LastIdx) ? '0 : index_q + 1'b1;
          state_d      = dtmf_pkg::StIdle;
        end
      end
      default: state_d = dtmf_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtmf_pkg::StIdle;
      tone_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      known_q     <= 1'b0;
      index_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tone_q      <= tone_d;
      row_q       <= row_d;
      col_q       <= col_d;
      known_q     <= known_d;
      index_q     <= index_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q        <= sum_d;
    out_sample_q <= out_sample_d;
    out_known_q  <= out_known_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_sample_q;
  assign m_axis_tuser_o  = out_known_q;

  a_accept_starts_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == dtmf_pkg::StSweep) && (tone_q == '0))
    else $error("accepted beat did not start the tone sweep at tone zero");

  a_no_pending_at_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dtmf_pkg::StDone) |-> !pend_q)
    else $error("rom data still pending when the sample is loaded");

  a_index_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    index_q <= LastIdx)
    else $error("sample index beyond table length");

  a_valid_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == dtmf_pkg::StDone))
    else $error("output beat raised outside the load state");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for dtmf_dual_tone_generator: key beats in, dual-tone samples out
// an in-bench sine table built from a Q30 series and a tone-pair model predict every sample; needs only the rtl
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TableLen   = 200;
  localparam int unsigned SampleRate = 44100;
  localparam int unsigned SineLen    = 1024;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 30;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  localparam int unsigned RowHz [4] = '{697, 770, 852, 941};
  localparam int unsigned ColHz [4] = '{1209, 1336, 1477, 1633};
  // keypad laid out row by row, four columns each
  localparam logic [7:0] KeyPad [16] = '{
    "1", "2", "3", "A", "4", "5", "6", "B", "7", "8", "9", "C", "*", "0", "#", "D"
  };

  typedef struct packed {
    logic signed [15:0] sample;
    logic               known;
  } tone_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  logic signed [15:0] sine_tab [SineLen];
  logic [1:0]  cur_row = 2'd0;
  logic [1:0]  cur_col = 2'd0;
  int unsigned sample_idx = 0;

  tone_beat_t  tone_sum_q [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned beats_checked = 0;
  int unsigned known_keys = 0;
  int unsigned other_keys = 0;
  int unsigned clipped_sums = 0;
  int unsigned index_wraps = 0;
  int unsigned cycles = 0;

  dtmf_dual_tone_generator #(
    .TableLength (TableLen),
    .SampleRateHz(SampleRate),
    .SineEntries (SineLen)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // round(16384 * sin(2*pi*k/SineLen)) from a Q30 Taylor series, folded by quadrant
  function automatic int q30_sine(int unsigned k);
    longint unsigned n, q, x, x2, term, acc;
    bit neg;
    int mag;
    n = SineLen;
    q = 4 * longint'(k);
    neg = 1'b0;
    if (q >= 2 * n) begin
      neg = 1'b1;
      q = q - 2 * n;
    end
    if (q > n) q = 2 * n - q;
    x = (HalfPiQ30 * q + n / 2) / n;
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (int i = 1; i <= 8; i++) begin
      term = (term * x2) >> 30;
      term = term / (longint'(2 * i) * longint'(2 * i + 1));
      if (i % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    mag = int'((acc + 64'd32768) >> 16);
    return neg ? -mag : mag;
  endfunction

  function automatic int tone_at(int unsigned hz, int unsigned n);
    longint unsigned phase;
    phase = (longint'(n) * hz * SineLen) / SampleRate;
    return sine_tab[phase % SineLen];
  endfunction

  function automatic int pair_sum(logic [1:0] row, logic [1:0] col, int unsigned n);
    return tone_at(ColHz[col], n) + tone_at(RowHz[row], n);
  endfunction

  function automatic bit lookup_key(input logic [7:0] key, output logic [1:0] row,
                                    output logic [1:0] col);
    logic [7:0] up;
    up = (key >= "a" && key <= "d") ? key - 8'd32 : key;
    row = 2'd0;
    col = 2'd0;
    for (int i = 0; i < 16; i++) begin
      if (KeyPad[i] == up) begin
        row = 2'(i / 4);
        col = 2'(i % 4);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic tone_beat_t next_dual_tone(logic [7:0] key);
    tone_beat_t beat;
    logic [1:0] row, col;
    int total;
    beat.known = lookup_key(key, row, col);
    if (beat.known) begin
      cur_row = row;
      cur_col = col;
      known_keys++;
    end else begin
      other_keys++;
    end
    total = pair_sum(cur_row, cur_col, sample_idx);
    if (total > 32767 || total < -32768) clipped_sums++;
    if (total > 32767) total = 32767;
    if (total < -32768) total = -32768;
    beat.sample = total[15:0];
    sample_idx++;
    if (sample_idx >= TableLen) begin
      sample_idx = 0;
      index_wraps++;
    end
    return beat;
  endfunction

  function automatic logic [7:0] stray_key();
    logic [7:0] key;
    logic [1:0] row, col;
    do key = 8'($urandom_range(255)); while (lookup_key(key, row, col));
    return key;
  endfunction

  task automatic play_key(input logic [7:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= key;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tone_sum_q.push_back(next_dual_tone(key));
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    tone_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (tone_sum_q.size() == 0) begin
        note_mismatch($sformatf("unexpected beat sample %0d key_known %0b",
                                $signed(m_axis_tdata_o), m_axis_tuser_o));
      end else begin
        want = tone_sum_q.pop_front();
        beats_checked++;
        if (m_axis_tdata_o !== want.sample)
          note_mismatch($sformatf("sample expected %0d actual %0d",
                                  want.sample, $signed(m_axis_tdata_o)));
        if (m_axis_tuser_o !== want.known)
          note_mismatch($sformatf("key_known expected %0b actual %0b",
                                  want.known, m_axis_tuser_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("dtmf_dual_tone_generator verification failed");
      $finish;
    end
  end

  // unknown keys right after reset keep the reset pair 697/1209
  task automatic test_reset_pair();
    play_key(8'h00);
    play_key(8'hff);
    play_key(8'h7f);
    play_key(8'h80);
  endtask

  task automatic test_every_key();
    for (int i = 0; i < 16; i++) play_key(KeyPad[i]);
    play_key("a");
    play_key("b");
    play_key("c");
    play_key("d");
    play_key("e");
  endtask

  // steer the free-running index to the largest and smallest sums the tone pairs reach
  task automatic test_peak_sums();
    int hi, lo, s;
    int unsigned hi_n, lo_n;
    logic [3:0] hi_key, lo_key;
    hi = -65536;
    lo = 65536;
    hi_n = 0;
    lo_n = 0;
    hi_key = 4'd0;
    lo_key = 4'd0;
    for (int unsigned n = 0; n < TableLen; n++) begin
      for (int p = 0; p < 16; p++) begin
        s = pair_sum(2'(p / 4), 2'(p % 4), n);
        if (s > hi) begin
          hi = s;
          hi_n = n;
          hi_key = 4'(p);
        end
        if (s < lo) begin
          lo = s;
          lo_n = n;
          lo_key = 4'(p);
        end
      end
    end
    while (sample_idx != hi_n) play_key(stray_key());
    play_key(KeyPad[hi_key]);
    while (sample_idx != lo_n) play_key(stray_key());
    play_key(KeyPad[lo_key]);
  endtask

  task automatic test_random_keys(input int unsigned count);
    logic [7:0] key;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70) begin
        key = KeyPad[$urandom_range(15)];
        if (key >= "A" && key <= "D" && $urandom_range(1)) key = key + 8'd32;
      end else begin
        key = 8'($urandom_range(255));
      end
      play_key(key);
    end
  endtask

  initial begin
    int unsigned per_phase;
    for (int unsigned k = 0; k < SineLen; k++) sine_tab[k] = q30_sine(k);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 17;
    recv_idle_pct = 53;
    test_reset_pair();
    test_every_key();
    test_peak_sums();
    // share what is left of about 500 keys between the three idling modes
    per_phase = (known_keys + other_keys < 350) ? (500 - (known_keys + other_keys)) / 3 : 50;
    test_random_keys(per_phase);

    send_idle_pct = 53;
    recv_idle_pct = 17;
    test_random_keys(per_phase);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_keys(per_phase);

    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (tone_sum_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("checked %0d samples: %0d recognized keys, %0d other keys", beats_checked,
             known_keys, other_keys);
    $display("%0d clipped sums, sample index wrapped %0d times, %0d mismatches",
             clipped_sums, index_wraps, mismatches);
    if (mismatches == 0 && tone_sum_q.size() == 0) begin
      $display("dtmf_dual_tone_generator verification clean");
    end else begin
      $display("dtmf_dual_tone_generator verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dtmf_pkg.sv
design/dtmf_sine_rom.sv
design/dtmf_phase_acc.sv
design/dtmf_dual_tone_generator.sv
tb/testbench.sv
